// ----- design/dsfe_pkg.sv -----
// ----------------------------------------------------------------------------
// dsfe_pkg: shared types and constants of the dshot frame encoder
// Mode and register codes, reset values and frame-building helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package dsfe_pkg;

  // number of throttle inputs on the top level
  localparam int MaxMotors         = 4;
  localparam int MotorCountDefault = 4;

  // field widths
  localparam int ThrW      = 17;   // requested throttle, signed Q2.15
  localparam int LastW     = 18;   // stored throttle, signed
  localparam int TW        = 16;   // clamped throttle 0..32768
  localparam int ValueW    = 11;   // dshot value
  localparam int FrameW    = 16;
  localparam int TickW     = 8;
  localparam int StepW     = 16;
  localparam int CmdW      = 16;
  localparam int CmdKeepW  = 6;    // commands kept are at most 47
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 16;

  // constants of the scaling
  localparam logic [TW-1:0]     OneQ15     = 16'h8000;
  localparam logic [ValueW-1:0] ValueScale = 11'd1999;
  localparam logic [ValueW-1:0] ValueBase  = 11'd48;
  localparam logic [CmdW-1:0]   CmdMax     = 16'd47;

  // register reset values
  localparam logic [StepW-1:0] MaxStepReset    = 16'd3277;
  localparam logic [TickW-1:0] OneHighReset    = 8'd100;
  localparam logic [TickW-1:0] OneLowReset     = 8'd33;
  localparam logic [TickW-1:0] ZeroHighReset   = 8'd50;
  localparam logic [TickW-1:0] ZeroLowReset    = 8'd83;

  typedef enum logic [1:0] {
    ModeThrottle = 2'd0,
    ModeCommand  = 2'd1,
    ModeStop     = 2'd2
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMaxStep  = 3'd0,
    CfgOneHigh  = 3'd1,
    CfgOneLow   = 3'd2,
    CfgZeroHigh = 3'd3,
    CfgZeroLow  = 3'd4
  } cfg_idx_e;

  // pulse timing handed to the serialiser
  typedef struct packed {
    logic [TickW-1:0] one_high;
    logic [TickW-1:0] one_low;
    logic [TickW-1:0] zero_high;
    logic [TickW-1:0] zero_low;
  } tick_cfg_t;

  // 48 + floor(t * 1999 / 32768), t in 0..32768
  function automatic logic [ValueW-1:0] scale_throttle(input logic [TW-1:0] t);
    logic [TW+ValueW-1:0] prod;
    prod = {{ValueW{1'b0}}, t} * {{TW{1'b0}}, ValueScale};
    return ValueBase + prod[TW+ValueW-2 -: ValueW];
  endfunction

  // value, zero telemetry bit and xor checksum of the three nibbles
  function automatic logic [FrameW-1:0] make_frame(input logic [ValueW-1:0] value);
    logic [11:0] word;
    logic [3:0]  csum;
    word = {value, 1'b0};
    csum = word[11:8] ^ word[7:4] ^ word[3:0];
    return {word, csum};
  endfunction

endpackage

`default_nettype wire

// ----- design/dsfe_serializer.sv -----
// ----------------------------------------------------------------------------
// dsfe_serializer: bit pulse generator
// Takes one set of motor frames and sends every frame MSB first, one bit pulse
// per cycle unless stalled, with high and low tick counts chosen by the bit value.
// ----------------------------------------------------------------------------
`default_nettype none

module dsfe_serializer #(
  parameter int MOTORS = dsfe_pkg::MotorCountDefault
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire dsfe_pkg::tick_cfg_t        ticks_i,
  input  wire                             ld_valid_i,
  input  wire [dsfe_pkg::FrameW-1:0]      ld_frames_i [MOTORS],
  output logic                            ld_ready_o,
  output logic                            out_valid_o,
  input  wire                             out_stall_i,
  output logic [1:0]                      motor_o,
  output logic [dsfe_pkg::FrameW-1:0]     frame_o,
  output logic [3:0]                      bit_index_o,
  output logic                            bit_value_o,
  output logic [dsfe_pkg::TickW-1:0]      high_ticks_o,
  output logic [dsfe_pkg::TickW-1:0]      low_ticks_o,
  output logic                            last_o
);

  localparam int MotW = (MOTORS > 1) ? $clog2(MOTORS) : 1;
  localparam logic [MotW-1:0] MotLast = MotW'(MOTORS - 1);

  logic                        busy_q;
  logic [MotW-1:0]             mot_cnt_q;
  logic [3:0]                  bit_cnt_q;
  logic [dsfe_pkg::FrameW-1:0] frames_q [MOTORS];

  logic advance;
  logic last_pulse;
  logic load;

  // current frame always sits in slot zero
  assign last_pulse  = (mot_cnt_q == MotLast) && (bit_cnt_q == 4'hF);
  assign advance     = busy_q && !out_stall_i;
  assign ld_ready_o  = !busy_q || (advance && last_pulse);
  assign load        = ld_valid_i && ld_ready_o;

  // pulse counters and frame shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      mot_cnt_q <= '0;
      bit_cnt_q <= '0;
    end else if (load) begin
      busy_q    <= 1'b1;
      mot_cnt_q <= '0;
      bit_cnt_q <= '0;
    end else if (advance) begin
      if (last_pulse) begin
        busy_q <= 1'b0;
      end
      bit_cnt_q <= bit_cnt_q + 4'd1;
      if (bit_cnt_q == 4'hF) begin
        mot_cnt_q <= mot_cnt_q + MotW'(1);
      end
    end
  end

  // frame store, no reset needed
  always_ff @(posedge clk_i) begin
    if (load) begin
      frames_q <= ld_frames_i;
    end else if (advance && bit_cnt_q == 4'hF) begin
      for (int i = 0; i < MOTORS - 1; i++) begin
        frames_q[i] <= frames_q[i+1];
      end
    end
  end

  // pulse fields
  assign out_valid_o  = busy_q;
  assign motor_o      = 2'(mot_cnt_q);
  assign frame_o      = frames_q[0];
  assign bit_index_o  = bit_cnt_q;
  assign bit_value_o  = frames_q[0][~bit_cnt_q];
  assign high_ticks_o = bit_value_o ? ticks_i.one_high : ticks_i.zero_high;
  assign low_ticks_o  = bit_value_o ? ticks_i.one_low : ticks_i.zero_low;
  assign last_o       = last_pulse;

endmodule

`default_nettype wire

// ----- design/dshot_throttle_frame_encoder_unit.sv -----
// ----------------------------------------------------------------------------
// dshot_throttle_frame_encoder_unit: dshot frame encoder for up to four motors
// Slew-limits and scales throttles, builds checksummed frames and emits them
// as bit pulses with tick counts.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid_i / in_stall_o): one transaction carries a mode,
//   four throttles and a command. Throttle mode slew-limits each motor and
//   updates its stored throttle on acceptance; command mode sends the command
//   (codes above 47 are dropped with no output); stop sends value 0.
//   Output channel (out_valid_o / out_stall_i): one transaction per bit pulse,
//   16 per motor, motor 0 first, MSB first; last_o marks the final pulse.
//   Config channel (cfg_valid_i / cfg_ready_o): always ready, write only while
//   the block is idle.
//   The first pulse of an input transaction comes out once the input stage,
//   the pending frame buffer and then the serialiser have taken it.
//   The item rate is set by the serialiser sending one pulse per cycle while the
//   output is not stalled. An input stage and a pending frame buffer hold two
//   further items, so input is taken while pulses go out.
//   A stalled output holds its pulse; the input stalls once both stages fill.
//   Reset clears all buffers, zeroes the stored throttles and loads the
//   default register values.
// ----------------------------------------------------------------------------
`default_nettype none

module dshot_throttle_frame_encoder_unit #(
  parameter int MOTOR_COUNT = dsfe_pkg::MotorCountDefault
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // config write
  input  wire                               cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire [dsfe_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire [dsfe_pkg::CfgDataW-1:0]      cfg_data_i,
  // input items
  input  wire                               in_valid_i,
  output logic                              in_stall_o,
  input  wire [1:0]                         mode_i,
  input  wire signed [dsfe_pkg::ThrW-1:0]   throttle_a_i,
  input  wire signed [dsfe_pkg::ThrW-1:0]   throttle_b_i,
  input  wire signed [dsfe_pkg::ThrW-1:0]   throttle_c_i,
  input  wire signed [dsfe_pkg::ThrW-1:0]   throttle_d_i,
  input  wire [dsfe_pkg::CmdW-1:0]          command_i,
  // bit pulses
  output logic                              out_valid_o,
  input  wire                               out_stall_i,
  output logic [1:0]                        motor_o,
  output logic [dsfe_pkg::FrameW-1:0]       frame_o,
  output logic [3:0]                        bit_index_o,
  output logic                              bit_value_o,
  output logic [dsfe_pkg::TickW-1:0]        high_ticks_o,
  output logic [dsfe_pkg::TickW-1:0]        low_ticks_o,
  output logic                              last_o
);

  localparam int MotorsUsed = (MOTOR_COUNT > dsfe_pkg::MaxMotors) ?
                              dsfe_pkg::MaxMotors : MOTOR_COUNT;
  localparam int DiffW = dsfe_pkg::LastW + 1;

  // configuration registers
  logic [dsfe_pkg::StepW-1:0] max_step_q;
  dsfe_pkg::tick_cfg_t        ticks_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_step_q        <= dsfe_pkg::MaxStepReset;
      ticks_q.one_high  <= dsfe_pkg::OneHighReset;
      ticks_q.one_low   <= dsfe_pkg::OneLowReset;
      ticks_q.zero_high <= dsfe_pkg::ZeroHighReset;
      ticks_q.zero_low  <= dsfe_pkg::ZeroLowReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        dsfe_pkg::CfgMaxStep:  max_step_q        <= cfg_data_i;
        dsfe_pkg::CfgOneHigh:  ticks_q.one_high  <= cfg_data_i[dsfe_pkg::TickW-1:0];
        dsfe_pkg::CfgOneLow:   ticks_q.one_low   <= cfg_data_i[dsfe_pkg::TickW-1:0];
        dsfe_pkg::CfgZeroHigh: ticks_q.zero_high <= cfg_data_i[dsfe_pkg::TickW-1:0];
        dsfe_pkg::CfgZeroLow:  ticks_q.zero_low  <= cfg_data_i[dsfe_pkg::TickW-1:0];
        default: ;
      endcase
    end
  end

  // handshake across the stages
  logic                         s1_valid_q;
  logic                         s1_thr_q;
  logic [dsfe_pkg::CmdKeepW-1:0] s1_cmd_q;
  logic [dsfe_pkg::TW-1:0]      s1_t_q [MotorsUsed];
  logic                         pend_valid_q;
  logic [dsfe_pkg::FrameW-1:0]  pend_frames_q [MotorsUsed];
  logic                         ser_ready;
  logic                         pend_take;
  logic                         s1_move;
  logic                         in_acc;

  assign pend_take  = pend_valid_q && ser_ready;
  assign s1_move    = s1_valid_q && (!pend_valid_q || pend_take);
  assign in_stall_o = s1_valid_q && !s1_move;
  assign in_acc     = in_valid_i && !in_stall_o;

  // slew limit and clamp against the stored throttles
  logic signed [dsfe_pkg::ThrW-1:0]  thr_in [dsfe_pkg::MaxMotors];
  logic signed [dsfe_pkg::LastW-1:0] last_q [MotorsUsed];
  logic signed [dsfe_pkg::LastW-1:0] limited [MotorsUsed];
  logic [dsfe_pkg::TW-1:0]           t_clamp [MotorsUsed];
  logic                              emit;
  logic                              cmd_ok;

  assign thr_in[0] = throttle_a_i;
  assign thr_in[1] = throttle_b_i;
  assign thr_in[2] = throttle_c_i;
  assign thr_in[3] = throttle_d_i;

  always_comb begin
    logic signed [DiffW-1:0] req;
    logic signed [DiffW-1:0] last;
    logic signed [DiffW-1:0] step;
    logic signed [DiffW-1:0] change;
    logic signed [DiffW-1:0] lim;
    step = DiffW'(signed'({1'b0, max_step_q}));
    for (int i = 0; i < MotorsUsed; i++) begin
      req    = DiffW'(thr_in[i]);
      last   = DiffW'(last_q[i]);
      change = req - last;
      if (change > step) begin
        lim = last + step;
      end else if (change < -step) begin
        lim = last - step;
      end else begin
        lim = req;
      end
      limited[i] = lim[dsfe_pkg::LastW-1:0];
      if (lim < 0) begin
        t_clamp[i] = '0;
      end else if (lim > DiffW'(signed'({1'b0, dsfe_pkg::OneQ15}))) begin
        t_clamp[i] = dsfe_pkg::OneQ15;
      end else begin
        t_clamp[i] = lim[dsfe_pkg::TW-1:0];
      end
    end
  end

  // decide whether the item produces pulses
  assign cmd_ok = command_i <= dsfe_pkg::CmdMax;

  always_comb begin
    case (mode_i)
      dsfe_pkg::ModeThrottle: emit = 1'b1;
      dsfe_pkg::ModeCommand:  emit = cmd_ok;
      dsfe_pkg::ModeStop:     emit = 1'b1;
      default:                emit = 1'b0;
    endcase
  end

  // stored throttles
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MotorsUsed; i++) begin
        last_q[i] <= '0;
      end
    end else if (in_acc && mode_i == dsfe_pkg::ModeThrottle) begin
      last_q <= limited;
    end
  end

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= emit;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_thr_q <= (mode_i == dsfe_pkg::ModeThrottle);
      s1_cmd_q <= (mode_i == dsfe_pkg::ModeCommand) ?
                  command_i[dsfe_pkg::CmdKeepW-1:0] : '0;
      s1_t_q   <= t_clamp;
    end
  end

  // scale and build frames into the pending buffer
  logic [dsfe_pkg::FrameW-1:0] frames_d [MotorsUsed];

  always_comb begin
    logic [dsfe_pkg::ValueW-1:0] value;
    for (int i = 0; i < MotorsUsed; i++) begin
      value = s1_thr_q ? dsfe_pkg::scale_throttle(s1_t_q[i]) :
                         dsfe_pkg::ValueW'(s1_cmd_q);
      frames_d[i] = dsfe_pkg::make_frame(value);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (s1_move) begin
      pend_valid_q <= 1'b1;
    end else if (pend_take) begin
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      pend_frames_q <= frames_d;
    end
  end

  // pulse output
  dsfe_serializer #(
    .MOTORS (MotorsUsed)
  ) u_serializer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ticks_i      (ticks_q),
    .ld_valid_i   (pend_valid_q),
    .ld_frames_i  (pend_frames_q),
    .ld_ready_o   (ser_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .motor_o      (motor_o),
    .frame_o      (frame_o),
    .bit_index_o  (bit_index_o),
    .bit_value_o  (bit_value_o),
    .high_ticks_o (high_ticks_o),
    .low_ticks_o  (low_ticks_o),
    .last_o       (last_o)
  );

  // checks
  a_last_on_final_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> bit_index_o == 4'hF)
    else $error("last flag away from the final bit of a frame");

  a_frame_checksum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> frame_o[3:0] == (frame_o[15:12] ^ frame_o[11:8] ^ frame_o[7:4]))
    else $error("frame checksum mismatch");

  a_bit_sequence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=>
      out_valid_o && bit_index_o == 4'($past(bit_index_o) + 4'd1))
    else $error("pulse sequence broken inside an item");

  a_tick_select: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> high_ticks_o == (bit_value_o ? ticks_q.one_high : ticks_q.zero_high))
    else $error("high tick count does not follow the bit value");

endmodule

`default_nettype wire

// ----- bench/dsfe_checker.sv -----
// ----------------------------------------------------------------------------
// dsfe_checker: pulse predictor and scoreboard for the dshot frame encoder
// Watches the config, input and pulse channels. Keeps its own copy of the
// registers and stored throttles, works out the 16 pulses per motor for each
// accepted input item that gives pulses, and compares every accepted pulse field by field.
// ----------------------------------------------------------------------------
module dsfe_checker (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  // config channel
  input  wire                             cfg_valid_i,
  input  wire                             cfg_ready_i,
  input  wire [dsfe_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire [dsfe_pkg::CfgDataW-1:0]    cfg_data_i,
  // input channel
  input  wire                             in_valid_i,
  input  wire                             in_stall_i,
  input  wire [1:0]                       mode_i,
  input  wire [dsfe_pkg::ThrW-1:0]        throttle_a_i,
  input  wire [dsfe_pkg::ThrW-1:0]        throttle_b_i,
  input  wire [dsfe_pkg::ThrW-1:0]        throttle_c_i,
  input  wire [dsfe_pkg::ThrW-1:0]        throttle_d_i,
  input  wire [dsfe_pkg::CmdW-1:0]        command_i,
  // pulse channel
  input  wire                             out_valid_i,
  input  wire                             out_stall_i,
  input  wire [1:0]                       motor_i,
  input  wire [dsfe_pkg::FrameW-1:0]      frame_i,
  input  wire [3:0]                       bit_index_i,
  input  wire                             bit_value_i,
  input  wire [dsfe_pkg::TickW-1:0]       high_ticks_i,
  input  wire [dsfe_pkg::TickW-1:0]       low_ticks_i,
  input  wire                             last_i,
  // status towards the bench top
  output int                              pending_o,
  output int                              fail_count_o
);

  localparam int Motors = (dsfe_pkg::MotorCountDefault > dsfe_pkg::MaxMotors) ?
                          dsfe_pkg::MaxMotors : dsfe_pkg::MotorCountDefault;

  typedef struct packed {
    logic [1:0]                  motor;
    logic [dsfe_pkg::FrameW-1:0] frame;
    logic [3:0]                  bit_index;
    logic                        bit_value;
    logic [dsfe_pkg::TickW-1:0]  high_ticks;
    logic [dsfe_pkg::TickW-1:0]  low_ticks;
    logic                        last;
  } pulse_t;

  pulse_t                            pulse_q[$];
  logic [dsfe_pkg::StepW-1:0]        max_step;
  dsfe_pkg::tick_cfg_t               ticks;
  logic signed [dsfe_pkg::LastW-1:0] last_thr [dsfe_pkg::MaxMotors];

  // one line per mismatch
  task automatic report(input string what, input int got, input int want);
    fail_count_o++;
    $display("checker: %s wrong at %0t: got %0d, expected %0d", what, $time, got, want);
  endtask

  // frame per motor, then sixteen pulses each, msb first
  task automatic queue_pulses(
      input logic [dsfe_pkg::MaxMotors-1:0][dsfe_pkg::ValueW-1:0] values);
    pulse_t                      p;
    logic [11:0]                 word;
    logic [3:0]                  csum;
    logic [dsfe_pkg::FrameW-1:0] fr;
    int                          m;
    int                          b;
    for (m = 0; m < Motors; m++) begin
      word = {values[m], 1'b0};
      csum = 4'h0;
      for (b = 0; b < 3; b++) csum ^= word[b*4 +: 4];
      fr = {word, csum};
      for (b = 0; b < dsfe_pkg::FrameW; b++) begin
        p.motor      = 2'(m);
        p.frame      = fr;
        p.bit_index  = 4'(b);
        p.bit_value  = fr[dsfe_pkg::FrameW-1-b];
        p.high_ticks = p.bit_value ? ticks.one_high : ticks.zero_high;
        p.low_ticks  = p.bit_value ? ticks.one_low : ticks.zero_low;
        p.last       = (m == Motors - 1) && (b == dsfe_pkg::FrameW - 1);
        pulse_q.push_back(p);
      end
    end
  endtask

  // slew limit, store, clamp and scale for throttle mode; command and stop
  task automatic predict_item(
      input logic [1:0] mode,
      input logic [dsfe_pkg::MaxMotors-1:0][dsfe_pkg::ThrW-1:0] req,
      input logic [dsfe_pkg::CmdW-1:0] cmd);
    logic [dsfe_pkg::MaxMotors-1:0][dsfe_pkg::ValueW-1:0] values;
    int m;
    int want;
    int held;
    int delta;
    int limit;
    int t;
    values = '0;
    limit  = int'(max_step);
    case (mode)
      dsfe_pkg::ModeThrottle: begin
        for (m = 0; m < Motors; m++) begin
          want  = int'(signed'(req[m]));
          held  = int'(last_thr[m]);
          delta = want - held;
          // a change equal to the step passes, only a larger one is cut
          if (delta > limit) want = held + limit;
          else if (delta < -limit) want = held - limit;
          last_thr[m] = dsfe_pkg::LastW'(want);
          t = want;
          if (t < 0) t = 0;
          if (t > int'(dsfe_pkg::OneQ15)) t = int'(dsfe_pkg::OneQ15);
          values[m] = dsfe_pkg::ValueW'(int'(dsfe_pkg::ValueBase) +
                                        ((t * int'(dsfe_pkg::ValueScale)) >>> 15));
        end
        queue_pulses(values);
      end
      dsfe_pkg::ModeCommand: begin
        // codes above the kept range produce nothing
        if (cmd <= dsfe_pkg::CmdMax) begin
          for (m = 0; m < Motors; m++) values[m] = dsfe_pkg::ValueW'(cmd);
          queue_pulses(values);
        end
      end
      dsfe_pkg::ModeStop: queue_pulses(values);
      default: ;
    endcase
  endtask

  // register writes, prediction on input transactions, compare on pulses
  always @(posedge clk_i or negedge rst_ni) begin
    pulse_t want;
    int     m;
    if (!rst_ni) begin
      max_step        = dsfe_pkg::MaxStepReset;
      ticks.one_high  = dsfe_pkg::OneHighReset;
      ticks.one_low   = dsfe_pkg::OneLowReset;
      ticks.zero_high = dsfe_pkg::ZeroHighReset;
      ticks.zero_low  = dsfe_pkg::ZeroLowReset;
      for (m = 0; m < dsfe_pkg::MaxMotors; m++) last_thr[m] = '0;
      pulse_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          dsfe_pkg::CfgMaxStep:  max_step        = cfg_data_i[dsfe_pkg::StepW-1:0];
          dsfe_pkg::CfgOneHigh:  ticks.one_high  = cfg_data_i[dsfe_pkg::TickW-1:0];
          dsfe_pkg::CfgOneLow:   ticks.one_low   = cfg_data_i[dsfe_pkg::TickW-1:0];
          dsfe_pkg::CfgZeroHigh: ticks.zero_high = cfg_data_i[dsfe_pkg::TickW-1:0];
          dsfe_pkg::CfgZeroLow:  ticks.zero_low  = cfg_data_i[dsfe_pkg::TickW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        predict_item(mode_i, {throttle_d_i, throttle_c_i, throttle_b_i, throttle_a_i},
                     command_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (pulse_q.size() == 0) begin
          report("unexpected pulse, motor", motor_i, 0);
        end else begin
          want = pulse_q.pop_front();
          if (motor_i !== want.motor) report("motor", motor_i, want.motor);
          if (frame_i !== want.frame) report("frame", frame_i, want.frame);
          if (bit_index_i !== want.bit_index) begin
            report("bit_index", bit_index_i, want.bit_index);
          end
          if (bit_value_i !== want.bit_value) begin
            report("bit_value", bit_value_i, want.bit_value);
          end
          if (high_ticks_i !== want.high_ticks) begin
            report("high_ticks", high_ticks_i, want.high_ticks);
          end
          if (low_ticks_i !== want.low_ticks) begin
            report("low_ticks", low_ticks_i, want.low_ticks);
          end
          if (last_i !== want.last) report("last", last_i, want.last);
        end
      end
      pending_o = pulse_q.size();
    end
  end

endmodule

// ----- bench/tb_dshot_throttle_frame_encoder_unit.sv -----
// ----------------------------------------------------------------------------
// tb_dshot_throttle_frame_encoder_unit: bench for the dshot frame encoder
// Directed items on slew limits, clamps, commands and stop, then random
// phases under several register settings with random gaps and stalls, a long
// output hold-off and a full drain. Checking lives in dsfe_checker.
// ----------------------------------------------------------------------------
module tb_dshot_throttle_frame_encoder_unit;

  localparam int ClkPeriod     = 12;
  localparam int ResetCycles   = 5;
  localparam int MaxGap        = 7;
  localparam int HoldOffCycles = 300;
  localparam int DrainCycles   = 10;
  localparam int TimeoutCycles = 600000;
  localparam int Phases        = 6;
  localparam int PhaseItems    = 24;

  localparam logic [1:0]                ModeUnused = 2'd3;
  localparam logic [dsfe_pkg::ThrW-1:0] ThrMaxPos  = 17'h0ffff;
  localparam logic [dsfe_pkg::ThrW-1:0] ThrMaxNeg  = 17'h10000;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [dsfe_pkg::CfgIdxW-1:0]  cfg_index;
  logic [dsfe_pkg::CfgDataW-1:0] cfg_data;
  logic                          in_valid;
  logic                          in_stall;
  logic [1:0]                    mode;
  logic [dsfe_pkg::ThrW-1:0]     thr_a;
  logic [dsfe_pkg::ThrW-1:0]     thr_b;
  logic [dsfe_pkg::ThrW-1:0]     thr_c;
  logic [dsfe_pkg::ThrW-1:0]     thr_d;
  logic [dsfe_pkg::CmdW-1:0]     command;
  logic                          out_valid;
  logic                          out_stall;
  logic [1:0]                    motor;
  logic [dsfe_pkg::FrameW-1:0]   frame;
  logic [3:0]                    bit_index;
  logic                          bit_value;
  logic [dsfe_pkg::TickW-1:0]    high_ticks;
  logic [dsfe_pkg::TickW-1:0]    low_ticks;
  logic                          last;

  int pending_pulses;
  int fail_total;
  int hold_requests;
  bit eager;

  dshot_throttle_frame_encoder_unit uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .mode_i       (mode),
    .throttle_a_i (thr_a),
    .throttle_b_i (thr_b),
    .throttle_c_i (thr_c),
    .throttle_d_i (thr_d),
    .command_i    (command),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .motor_o      (motor),
    .frame_o      (frame),
    .bit_index_o  (bit_index),
    .bit_value_o  (bit_value),
    .high_ticks_o (high_ticks),
    .low_ticks_o  (low_ticks),
    .last_o       (last)
  );

  dsfe_checker pulse_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .mode_i       (mode),
    .throttle_a_i (thr_a),
    .throttle_b_i (thr_b),
    .throttle_c_i (thr_c),
    .throttle_d_i (thr_d),
    .command_i    (command),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .motor_i      (motor),
    .frame_i      (frame),
    .bit_index_i  (bit_index),
    .bit_value_i  (bit_value),
    .high_ticks_i (high_ticks),
    .low_ticks_i  (low_ticks),
    .last_i       (last),
    .pending_o    (pending_pulses),
    .fail_count_o (fail_total)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  // run limit
  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("tb: failure");
    $finish;
  end

  // pulse receiver: random stall per transaction, long hold-off on request
  initial begin
    int gap;
    int served;
    out_stall = 1'b0;
    served    = 0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_requests > served) begin
        served++;
        out_stall <= 1'b1;
        repeat (HoldOffCycles) @(negedge clk);
      end
      gap = eager ? 0 : $urandom_range(0, MaxGap);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // offer one transaction after a random gap; returns at the accepting edge
  task automatic send(input logic [1:0] m, input logic [dsfe_pkg::ThrW-1:0] a,
                      input logic [dsfe_pkg::ThrW-1:0] b,
                      input logic [dsfe_pkg::ThrW-1:0] c,
                      input logic [dsfe_pkg::ThrW-1:0] d,
                      input logic [dsfe_pkg::CmdW-1:0] cmd);
    int gap;
    gap = eager ? 0 : $urandom_range(0, MaxGap);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    thr_a    <= a;
    thr_b    <= b;
    thr_c    <= c;
    thr_d    <= d;
    command  <= cmd;
    do @(posedge clk); while (in_stall);
  endtask

  // drop valid, wait for every expected pulse, then let the pipeline settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pulses != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // one register write; valid stays up for a following write
  task automatic write_reg(input dsfe_pkg::cfg_idx_e idx,
                           input logic [dsfe_pkg::CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic write_timing(input logic [dsfe_pkg::StepW-1:0] step,
                              input logic [dsfe_pkg::TickW-1:0] oh,
                              input logic [dsfe_pkg::TickW-1:0] ol,
                              input logic [dsfe_pkg::TickW-1:0] zh,
                              input logic [dsfe_pkg::TickW-1:0] zl);
    write_reg(dsfe_pkg::CfgMaxStep, dsfe_pkg::CfgDataW'(step));
    write_reg(dsfe_pkg::CfgOneHigh, dsfe_pkg::CfgDataW'(oh));
    write_reg(dsfe_pkg::CfgOneLow, dsfe_pkg::CfgDataW'(ol));
    write_reg(dsfe_pkg::CfgZeroHigh, dsfe_pkg::CfgDataW'(zh));
    write_reg(dsfe_pkg::CfgZeroLow, dsfe_pkg::CfgDataW'(zl));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [dsfe_pkg::ThrW-1:0] rand_throttle();
    case ($urandom_range(0, 5))
      0:       return ThrMaxPos;
      1:       return ThrMaxNeg;
      2, 3:    return dsfe_pkg::ThrW'($urandom_range(0, dsfe_pkg::OneQ15));
      default: return dsfe_pkg::ThrW'($urandom);
    endcase
  endfunction

  function automatic logic [dsfe_pkg::TickW-1:0] rand_ticks();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return dsfe_pkg::TickW'($urandom);
    endcase
  endfunction

  // random transaction; tells whether it gives pulses
  task automatic send_random(output bit gives_pulses);
    int                        pick;
    logic [1:0]                m;
    logic [dsfe_pkg::CmdW-1:0] cmd;
    pick = $urandom_range(0, 99);
    cmd  = dsfe_pkg::CmdW'($urandom);
    if (pick < 65) begin
      m = dsfe_pkg::ModeThrottle;
    end else if (pick < 82) begin
      m = dsfe_pkg::ModeCommand;
      if ($urandom_range(0, 3) != 0) begin
        cmd = dsfe_pkg::CmdW'($urandom_range(0, dsfe_pkg::CmdMax));
      end
    end else if (pick < 92) begin
      m = dsfe_pkg::ModeStop;
    end else begin
      m = ModeUnused;
    end
    send(m, rand_throttle(), rand_throttle(), rand_throttle(), rand_throttle(), cmd);
    gives_pulses = (m == dsfe_pkg::ModeThrottle) || (m == dsfe_pkg::ModeStop) ||
                   (m == dsfe_pkg::ModeCommand && cmd <= dsfe_pkg::CmdMax);
  endtask

  // stimulus and verdict
  initial begin
    int  phase;
    int  done;
    bit  counted;
    bit  hold_used;
    bit  pause_used;
    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    mode          = '0;
    thr_a         = '0;
    thr_b         = '0;
    thr_c         = '0;
    thr_d         = '0;
    command       = '0;
    hold_requests = 0;
    eager         = 1'b0;
    hold_used     = 1'b0;
    pause_used    = 1'b0;
    repeat (ResetCycles) @(negedge clk);
    rst_n <= 1'b1;

    // reset registers: zero request, exact step passes, one more is cut
    send(dsfe_pkg::ModeThrottle, '0, '0, '0, '0, '0);
    send(dsfe_pkg::ModeThrottle, dsfe_pkg::ThrW'(3277), dsfe_pkg::ThrW'(3278),
         dsfe_pkg::ThrW'(-3277), dsfe_pkg::ThrW'(-3278), '0);
    // commands at the edge of the kept range, dropped ones, stop, unused mode
    send(dsfe_pkg::ModeCommand, '0, '0, '0, '0, '0);
    send(dsfe_pkg::ModeCommand, '0, '0, '0, '0, dsfe_pkg::CmdMax);
    send(dsfe_pkg::ModeCommand, '0, '0, '0, '0, dsfe_pkg::CmdMax + 1'b1);
    send(dsfe_pkg::ModeCommand, '0, '0, '0, '0, '1);
    send(dsfe_pkg::ModeStop, ThrMaxPos, ThrMaxNeg, ThrMaxPos, ThrMaxNeg, '1);
    send(ModeUnused, rand_throttle(), rand_throttle(), rand_throttle(), rand_throttle(),
         dsfe_pkg::CmdW'($urandom));
    wait_idle();

    // full step with extreme tick counts: clamp above one and below zero
    write_timing(dsfe_pkg::OneQ15, '1, '0, '0, '1);
    repeat (3) send(dsfe_pkg::ModeThrottle, ThrMaxPos, ThrMaxPos, ThrMaxPos, ThrMaxPos, '0);
    repeat (3) send(dsfe_pkg::ModeThrottle, ThrMaxNeg, ThrMaxNeg, ThrMaxNeg, ThrMaxNeg, '0);
    // climb back to exactly one through full-size steps and a final small step
    send(dsfe_pkg::ModeThrottle, '0, '0, '0, '0, '0);
    send(dsfe_pkg::ModeThrottle, dsfe_pkg::ThrW'(32767), dsfe_pkg::ThrW'(32767),
         dsfe_pkg::ThrW'(32767), dsfe_pkg::ThrW'(32767), '0);
    send(dsfe_pkg::ModeThrottle, dsfe_pkg::ThrW'(dsfe_pkg::OneQ15),
         dsfe_pkg::ThrW'(dsfe_pkg::OneQ15), dsfe_pkg::ThrW'(dsfe_pkg::OneQ15),
         dsfe_pkg::ThrW'(dsfe_pkg::OneQ15), '0);
    send(dsfe_pkg::ModeCommand, '0, '0, '0, '0, dsfe_pkg::CmdMax);
    send(dsfe_pkg::ModeStop, '0, '0, '0, '0, '0);

    // random phases under different register settings
    for (phase = 0; phase < Phases; phase++) begin
      wait_idle();
      case (phase)
        0: write_timing('0, '0, '1, '1, '0);
        1: write_timing(dsfe_pkg::OneQ15, '1, '1, '0, '0);
        Phases - 1: write_timing(dsfe_pkg::MaxStepReset, dsfe_pkg::OneHighReset,
                                 dsfe_pkg::OneLowReset, dsfe_pkg::ZeroHighReset,
                                 dsfe_pkg::ZeroLowReset);
        default: write_timing(($urandom_range(0, 1) != 0) ?
                                dsfe_pkg::StepW'($urandom_range(1, 4000)) :
                                dsfe_pkg::StepW'($urandom_range(0, dsfe_pkg::OneQ15)),
                              rand_ticks(), rand_ticks(), rand_ticks(), rand_ticks());
      endcase
      // one phase without any gaps on either side
      eager = (phase == 3);
      done  = 0;
      while (done < PhaseItems) begin
        // output held off while the input keeps offering, so the block fills
        if (phase == 2 && done == 5 && !hold_used) begin
          hold_used = 1'b1;
          hold_requests++;
        end
        // sender pause until every pulse is out
        if (phase == 4 && done == PhaseItems / 2 && !pause_used) begin
          pause_used = 1'b1;
          wait_idle();
        end
        send_random(counted);
        if (counted) done++;
      end
    end
    eager = 1'b0;

    wait_idle();
    if (fail_total == 0 && pending_pulses == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- dshot_throttle_frame_encoder_unit.f -----
design/dsfe_pkg.sv
design/dsfe_serializer.sv
design/dshot_throttle_frame_encoder_unit.sv
bench/dsfe_checker.sv
bench/tb_dshot_throttle_frame_encoder_unit.sv
